// ===== rtl/core/keycode_to_keysym_mapper_macros.svh =====
// Assertion macros shared by the keymap RTL.
`ifndef KEYCODE_TO_KEYSYM_MAPPER_MACROS_SVH
`define KEYCODE_TO_KEYSYM_MAPPER_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define KKM_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("keymap check failed");

// Next-cycle implication checked outside reset.
`define KKM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("keymap check failed");

`endif

// ===== rtl/core/kkm_pkg.sv =====
// Package with the modifier layout and the keymap ROM functions.
package kkm_pkg;

    localparam int TABLE_SIZE = 127;

    localparam logic [5:0] M_SHIFT = 6'h01;
    localparam logic [5:0] M_CAPS  = 6'h02;
    localparam logic [5:0] M_CTRL  = 6'h04;
    localparam logic [5:0] M_ALT   = 6'h08;
    localparam logic [5:0] M_NUM   = 6'h10;
    localparam logic [5:0] M_META  = 6'h20;

    localparam logic [1:0] KS_RELEASE = 2'd0;
    localparam logic [1:0] KS_PRESS   = 2'd1;

    typedef logic [15:0] sym_t;

    // Unshifted symbols.
    function automatic sym_t rom_normal(input logic [6:0] c);
        sym_t s;
        s = 16'h0;
        unique case (c)
            7'd1: s = 16'hff1b;
            7'd2: s = 16'h31; 7'd3: s = 16'h32; 7'd4: s = 16'h33; 7'd5: s = 16'h34;
            7'd6: s = 16'h35; 7'd7: s = 16'h36; 7'd8: s = 16'h37; 7'd9: s = 16'h38;
            7'd10: s = 16'h39; 7'd11: s = 16'h30; 7'd12: s = 16'h2d; 7'd13: s = 16'h3d;
            7'd14: s = 16'hff08; 7'd15: s = 16'hff09;
            7'd16: s = 16'h71; 7'd17: s = 16'h77; 7'd18: s = 16'h65; 7'd19: s = 16'h72;
            7'd20: s = 16'h74; 7'd21: s = 16'h79; 7'd22: s = 16'h75; 7'd23: s = 16'h69;
            7'd24: s = 16'h6f; 7'd25: s = 16'h70; 7'd26: s = 16'h5b; 7'd27: s = 16'h5d;
            7'd28: s = 16'hff0d; 7'd29: s = 16'hffe3;
            7'd30: s = 16'h61; 7'd31: s = 16'h73; 7'd32: s = 16'h64; 7'd33: s = 16'h66;
            7'd34: s = 16'h67; 7'd35: s = 16'h68; 7'd36: s = 16'h6a; 7'd37: s = 16'h6b;
            7'd38: s = 16'h6c; 7'd39: s = 16'h3b; 7'd40: s = 16'h27; 7'd41: s = 16'h60;
            7'd42: s = 16'hffe1; 7'd43: s = 16'h5c;
            7'd44: s = 16'h7a; 7'd45: s = 16'h78; 7'd46: s = 16'h63; 7'd47: s = 16'h76;
            7'd48: s = 16'h62; 7'd49: s = 16'h6e; 7'd50: s = 16'h6d; 7'd51: s = 16'h2c;
            7'd52: s = 16'h2e; 7'd53: s = 16'h2f;
            7'd54: s = 16'hffe2; 7'd55: s = 16'hffaa; 7'd56: s = 16'hffe9;
            7'd57: s = 16'h20; 7'd58: s = 16'hffe5;
            7'd59: s = 16'hffbe; 7'd60: s = 16'hffbf; 7'd61: s = 16'hffc0;
            7'd62: s = 16'hffc1; 7'd63: s = 16'hffc2; 7'd64: s = 16'hffc3;
            7'd65: s = 16'hffc4; 7'd66: s = 16'hffc5; 7'd67: s = 16'hffc6;
            7'd68: s = 16'hffc7; 7'd69: s = 16'hff7f; 7'd70: s = 16'hff14;
            7'd71: s = 16'hff95; 7'd72: s = 16'hff97; 7'd73: s = 16'hff9a;
            7'd74: s = 16'hffad; 7'd75: s = 16'hff96; 7'd76: s = 16'hff9d;
            7'd77: s = 16'hff98; 7'd78: s = 16'hffab; 7'd79: s = 16'hff9c;
            7'd80: s = 16'hff99; 7'd81: s = 16'hff9b; 7'd82: s = 16'hff9e;
            7'd83: s = 16'hff9f; 7'd87: s = 16'hffc8; 7'd88: s = 16'hffc9;
            7'd96: s = 16'hff8d; 7'd97: s = 16'hffe4; 7'd98: s = 16'hffaf;
            7'd100: s = 16'hffea; 7'd101: s = 16'hff0a; 7'd102: s = 16'hff50;
            7'd103: s = 16'hff52; 7'd104: s = 16'hff55; 7'd105: s = 16'hff51;
            7'd106: s = 16'hff53; 7'd107: s = 16'hff57; 7'd108: s = 16'hff54;
            7'd109: s = 16'hff56; 7'd110: s = 16'hff63; 7'd111: s = 16'hffff;
            7'd117: s = 16'hffbd; 7'd125: s = 16'hffe7; 7'd126: s = 16'hffe8;
            default: s = 16'h0;
        endcase
        return s;
    endfunction

    // Keypad digits with num lock on.
    function automatic sym_t rom_numlock(input logic [6:0] c);
        sym_t s;
        s = 16'h0;
        unique case (c)
            7'd71: s = 16'hffb7; 7'd72: s = 16'hffb8; 7'd73: s = 16'hffb9;
            7'd75: s = 16'hffb4; 7'd76: s = 16'hffb5; 7'd77: s = 16'hffb6;
            7'd79: s = 16'hffb1; 7'd80: s = 16'hffb2; 7'd81: s = 16'hffb3;
            7'd82: s = 16'hffb0;
            default: s = 16'h0;
        endcase
        return s;
    endfunction

    // Letters only, upper case.
    function automatic sym_t rom_capslock(input logic [6:0] c);
        sym_t s;
        s = 16'h0;
        unique case (c)
            7'd16: s = 16'h51; 7'd17: s = 16'h57; 7'd18: s = 16'h45; 7'd19: s = 16'h52;
            7'd20: s = 16'h54; 7'd21: s = 16'h59; 7'd22: s = 16'h55; 7'd23: s = 16'h49;
            7'd24: s = 16'h4f; 7'd25: s = 16'h50;
            7'd30: s = 16'h41; 7'd31: s = 16'h53; 7'd32: s = 16'h44; 7'd33: s = 16'h46;
            7'd34: s = 16'h47; 7'd35: s = 16'h48; 7'd36: s = 16'h4a; 7'd37: s = 16'h4b;
            7'd38: s = 16'h4c;
            7'd44: s = 16'h5a; 7'd45: s = 16'h58; 7'd46: s = 16'h43; 7'd47: s = 16'h56;
            7'd48: s = 16'h42; 7'd49: s = 16'h4e; 7'd50: s = 16'h4d;
            default: s = 16'h0;
        endcase
        return s;
    endfunction

    // Shifted symbols: capitals plus the shifted punctuation.
    function automatic sym_t rom_shift(input logic [6:0] c);
        sym_t s;
        s = rom_capslock(c);
        unique case (c)
            7'd2: s = 16'h21; 7'd3: s = 16'h40; 7'd4: s = 16'h23; 7'd5: s = 16'h24;
            7'd6: s = 16'h25; 7'd7: s = 16'h5e; 7'd8: s = 16'h26; 7'd9: s = 16'h2a;
            7'd10: s = 16'h28; 7'd11: s = 16'h29; 7'd12: s = 16'h5f; 7'd13: s = 16'h2b;
            7'd26: s = 16'h7b; 7'd27: s = 16'h7d;
            7'd39: s = 16'h3a; 7'd40: s = 16'h22; 7'd41: s = 16'h7e; 7'd43: s = 16'h7c;
            7'd51: s = 16'h3c; 7'd52: s = 16'h3e; 7'd53: s = 16'h3f;
            default: ;
        endcase
        return s;
    endfunction

    // Modifier mask of a modifier key, zero for other keys.
    function automatic logic [5:0] rom_modmask(input logic [6:0] c);
        logic [5:0] m;
        m = 6'h0;
        unique case (c)
            7'd29, 7'd97:  m = M_CTRL;
            7'd42, 7'd54:  m = M_SHIFT;
            7'd56, 7'd100: m = M_ALT;
            7'd58:         m = M_CAPS;
            7'd69:         m = M_NUM;
            7'd125, 7'd126: m = M_META;
            default:       m = 6'h0;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/core/keycode_to_keysym_mapper.sv =====
// Top level of the US PC key code to keysym mapper.
// Each request is registered at the input; from there the modifier register
// is updated and the four keymap ROMs are looked up in priority order, and the
// answer lands in the output register. A request is accepted every cycle while
// the output side takes results; each request gives exactly one result, with
// delivered low (and all fields zero) when no symbol results.
`include "keycode_to_keysym_mapper_macros.svh"
module keycode_to_keysym_mapper (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [1:0]  s_key_state,
    input  logic [15:0] s_key_code,
    input  logic        s_led_numlock,
    input  logic        s_led_capslock,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_delivered,
    output logic [6:0]  m_out_code,
    output kkm_pkg::sym_t m_keysym,
    output logic [5:0]  m_modifiers
);
    import kkm_pkg::*;

    logic        in_vld_reg;
    logic        kind_reg, lnum_reg, lcaps_reg, inrange_reg;
    logic [1:0]  state_reg;
    logic [6:0]  code_reg;
    logic [5:0]  mod_reg, mod_next;
    logic        out_vld_reg;
    logic        dlv_reg, dlv_next;
    logic [6:0]  ocode_reg;
    sym_t        sym_reg, sym_next;
    logic [5:0]  omod_reg;
    logic        adv;
    logic [5:0]  mask;
    logic        is_lock;

    // Stage advances when the output register is empty or being drained.
    assign adv     = !out_vld_reg || m_ready;
    assign s_ready = !in_vld_reg || adv;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            kind_reg    <= s_kind;
            state_reg   <= s_key_state;
            code_reg    <= s_key_code[6:0];
            inrange_reg <= (s_key_code < 16'(TABLE_SIZE));
            lnum_reg    <= s_led_numlock;
            lcaps_reg   <= s_led_capslock;
        end
    end

    // Modifier update and prioritized ROM lookup.
    always_comb begin
        mask     = rom_modmask(code_reg);
        is_lock  = (mask == M_CAPS) || (mask == M_NUM);
        mod_next = mod_reg;
        sym_next = '0;
        dlv_next = 1'b0;
        if (kind_reg) begin
            mod_next = (lnum_reg ? M_NUM : 6'h0) | (lcaps_reg ? M_CAPS : 6'h0);
        end else if (inrange_reg) begin
            if (mask != 6'h0) begin
                if (state_reg == KS_PRESS) begin
                    mod_next = is_lock ? (mod_reg ^ mask) : (mod_reg | mask);
                end else if (state_reg == KS_RELEASE && !is_lock) begin
                    mod_next = mod_reg & ~mask;
                end
            end else if (state_reg != KS_RELEASE) begin
                if (mod_reg[4]) sym_next = rom_numlock(code_reg);
                if (sym_next == '0 && mod_reg[0]) sym_next = rom_shift(code_reg);
                if (sym_next == '0 && mod_reg[1]) sym_next = rom_capslock(code_reg);
                if (sym_next == '0) sym_next = rom_normal(code_reg);
                dlv_next = (sym_next != '0);
            end
        end
    end

    // Modifier register and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_reg     <= 6'h0;
            out_vld_reg <= 1'b0;
        end else begin
            if (adv) begin
                out_vld_reg <= in_vld_reg;
            end
            if (adv && in_vld_reg) begin
                mod_reg <= mod_next;
            end
        end
        if (adv && in_vld_reg) begin
            dlv_reg   <= dlv_next;
            sym_reg   <= sym_next;
            ocode_reg <= dlv_next ? code_reg : 7'h0;
            omod_reg  <= dlv_next ? mod_reg : 6'h0;
        end
    end

    assign m_valid     = out_vld_reg;
    assign m_delivered = dlv_reg;
    assign m_out_code  = ocode_reg;
    assign m_keysym    = sym_reg;
    assign m_modifiers = omod_reg;

    `KKM_ASSERT_IMP(a_sym_nonzero, aclk, aresetn, m_valid && m_delivered, m_keysym != '0)
    `KKM_ASSERT_IMP(a_empty_zero, aclk, aresetn, m_valid && !m_delivered,
        m_keysym == '0 && m_out_code == 7'h0 && m_modifiers == 6'h0)
    `KKM_ASSERT_NEXT(a_kind_reload, aclk, aresetn, adv && in_vld_reg && kind_reg,
        mod_reg[0] == 1'b0 && mod_reg[2] == 1'b0 && mod_reg[3] == 1'b0 && mod_reg[5] == 1'b0)
    `KKM_ASSERT_NEXT(a_hold_out, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_keysym) && $stable(m_delivered))
endmodule

// ===== tb/sv/keycode_to_keysym_mapper_checker.sv =====
`timescale 1ns / 1ps
// Checker for the keymap: watches both channels, predicts each result and compares it.
module keycode_to_keysym_mapper_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_kind,
    input  logic [1:0]  s_key_state,
    input  logic [15:0] s_key_code,
    input  logic        s_led_numlock,
    input  logic        s_led_capslock,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_delivered,
    input  logic [6:0]  m_out_code,
    input  logic [15:0] m_keysym,
    input  logic [5:0]  m_modifiers,
    output int          fail_count,
    output int          pending_syms,
    output int          delivered_count
);
    import kkm_pkg::*;

    typedef struct packed {
        logic        delivered;
        logic [6:0]  code;
        logic [15:0] sym;
        logic [5:0]  mods;
    } keysym_event_t;

    keysym_event_t expected_syms[$];
    logic [5:0]    mod_state;

    // Unshifted keymap, indexed by key code.
    function automatic logic [15:0] plain_sym(input int c);
        case (c)
            1: return 16'hff1b;
            2: return 16'h31; 3: return 16'h32; 4: return 16'h33; 5: return 16'h34;
            6: return 16'h35; 7: return 16'h36; 8: return 16'h37; 9: return 16'h38;
            10: return 16'h39; 11: return 16'h30; 12: return 16'h2d; 13: return 16'h3d;
            14: return 16'hff08; 15: return 16'hff09;
            16: return 16'h71; 17: return 16'h77; 18: return 16'h65; 19: return 16'h72;
            20: return 16'h74; 21: return 16'h79; 22: return 16'h75; 23: return 16'h69;
            24: return 16'h6f; 25: return 16'h70; 26: return 16'h5b; 27: return 16'h5d;
            28: return 16'hff0d; 29: return 16'hffe3;
            30: return 16'h61; 31: return 16'h73; 32: return 16'h64; 33: return 16'h66;
            34: return 16'h67; 35: return 16'h68; 36: return 16'h6a; 37: return 16'h6b;
            38: return 16'h6c; 39: return 16'h3b; 40: return 16'h27; 41: return 16'h60;
            42: return 16'hffe1; 43: return 16'h5c;
            44: return 16'h7a; 45: return 16'h78; 46: return 16'h63; 47: return 16'h76;
            48: return 16'h62; 49: return 16'h6e; 50: return 16'h6d; 51: return 16'h2c;
            52: return 16'h2e; 53: return 16'h2f; 54: return 16'hffe2; 55: return 16'hffaa;
            56: return 16'hffe9; 57: return 16'h20; 58: return 16'hffe5;
            59: return 16'hffbe; 60: return 16'hffbf; 61: return 16'hffc0;
            62: return 16'hffc1; 63: return 16'hffc2; 64: return 16'hffc3;
            65: return 16'hffc4; 66: return 16'hffc5; 67: return 16'hffc6;
            68: return 16'hffc7; 69: return 16'hff7f; 70: return 16'hff14;
            71: return 16'hff95; 72: return 16'hff97; 73: return 16'hff9a;
            74: return 16'hffad; 75: return 16'hff96; 76: return 16'hff9d;
            77: return 16'hff98; 78: return 16'hffab; 79: return 16'hff9c;
            80: return 16'hff99; 81: return 16'hff9b; 82: return 16'hff9e;
            83: return 16'hff9f; 87: return 16'hffc8; 88: return 16'hffc9;
            96: return 16'hff8d; 97: return 16'hffe4; 98: return 16'hffaf;
            100: return 16'hffea; 101: return 16'hff0a; 102: return 16'hff50;
            103: return 16'hff52; 104: return 16'hff55; 105: return 16'hff51;
            106: return 16'hff53; 107: return 16'hff57; 108: return 16'hff54;
            109: return 16'hff56; 110: return 16'hff63; 111: return 16'hffff;
            117: return 16'hffbd; 125: return 16'hffe7; 126: return 16'hffe8;
            default: return 16'h0;
        endcase
    endfunction

    // Keypad digits when num lock is on.
    function automatic logic [15:0] keypad_sym(input int c);
        case (c)
            71: return 16'hffb7; 72: return 16'hffb8; 73: return 16'hffb9;
            75: return 16'hffb4; 76: return 16'hffb5; 77: return 16'hffb6;
            79: return 16'hffb1; 80: return 16'hffb2; 81: return 16'hffb3;
            82: return 16'hffb0;
            default: return 16'h0;
        endcase
    endfunction

    // Letter keys give their capital, the ASCII offset being 0x20.
    function automatic logic [15:0] capital_sym(input int c);
        if ((c >= 16 && c <= 25) || (c >= 30 && c <= 38) || (c >= 44 && c <= 50)) begin
            return plain_sym(c) - 16'h20;
        end
        return 16'h0;
    endfunction

    // Shifted symbols: capitals plus the shifted punctuation and digits.
    function automatic logic [15:0] shifted_sym(input int c);
        case (c)
            2: return 16'h21; 3: return 16'h40; 4: return 16'h23; 5: return 16'h24;
            6: return 16'h25; 7: return 16'h5e; 8: return 16'h26; 9: return 16'h2a;
            10: return 16'h28; 11: return 16'h29; 12: return 16'h5f; 13: return 16'h2b;
            26: return 16'h7b; 27: return 16'h7d; 39: return 16'h3a; 40: return 16'h22;
            41: return 16'h7e; 43: return 16'h7c; 51: return 16'h3c; 52: return 16'h3e;
            53: return 16'h3f;
            default: return capital_sym(c);
        endcase
    endfunction

    // Modifier bit driven by a modifier key, zero for any other key.
    function automatic logic [5:0] modifier_of(input int c);
        case (c)
            29, 97:   return M_CTRL;
            42, 54:   return M_SHIFT;
            56, 100:  return M_ALT;
            58:       return M_CAPS;
            69:       return M_NUM;
            125, 126: return M_META;
            default:  return 6'h0;
        endcase
    endfunction

    // Update the modifier state for one request and return its expected result.
    function automatic keysym_event_t translate_key(input logic kind, input logic [1:0] st,
                                                    input logic [15:0] code,
                                                    input logic num_led,
                                                    input logic caps_led);
        keysym_event_t r;
        logic [5:0]    m;
        logic [15:0]   s;
        int            c;
        r = '0;
        c = code;
        s = 16'h0;
        if (kind) begin
            mod_state = (num_led ? M_NUM : 6'h0) | (caps_led ? M_CAPS : 6'h0);
            return r;
        end
        if (c >= TABLE_SIZE) return r;
        m = modifier_of(c);
        if (m != 6'h0) begin
            if (st == KS_PRESS) begin
                if (m == M_CAPS || m == M_NUM) mod_state = mod_state ^ m;
                else mod_state = mod_state | m;
            end else if (st == KS_RELEASE && m != M_CAPS && m != M_NUM) begin
                mod_state = mod_state & ~m;
            end
            return r;
        end
        if (st == KS_RELEASE) return r;
        if (mod_state & M_NUM) s = keypad_sym(c);
        if (s == 0 && (mod_state & M_SHIFT)) s = shifted_sym(c);
        if (s == 0 && (mod_state & M_CAPS)) s = capital_sym(c);
        if (s == 0) s = plain_sym(c);
        if (s == 0) return r;
        r.delivered = 1'b1;
        r.code = code[6:0];
        r.sym = s;
        r.mods = mod_state;
        return r;
    endfunction

    // Print one line for a mismatch and count it.
    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("[%0t] keymap error: %s got %h expected %h", $realtime, what, got, want);
        fail_count++;
    endtask

    assign pending_syms = expected_syms.size();

    // Predict on each accepted request and compare each accepted result.
    always @(posedge aclk) begin
        keysym_event_t want;
        if (!aresetn) begin
            mod_state = 6'h0;
            expected_syms.delete();
            fail_count = 0;
            delivered_count <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_syms.size() == 0) begin
                    report_mismatch("result with nothing pending", m_keysym, 16'h0);
                end else begin
                    want = expected_syms.pop_front();
                    if (m_delivered) delivered_count <= delivered_count + 1;
                    if (m_delivered !== want.delivered)
                        report_mismatch("delivered", m_delivered, want.delivered);
                    if (m_out_code !== want.code)
                        report_mismatch("out_code", m_out_code, want.code);
                    if (m_keysym !== want.sym)
                        report_mismatch("keysym", m_keysym, want.sym);
                    if (m_modifiers !== want.mods)
                        report_mismatch("modifiers", m_modifiers, want.mods);
                end
            end
            if (s_valid && s_ready) begin
                expected_syms.push_back(translate_key(s_kind, s_key_state, s_key_code,
                                                      s_led_numlock, s_led_capslock));
            end
        end
    end
endmodule

// ===== tb/sv/keycode_to_keysym_mapper_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the keymap: drives key requests, stalls the output side, gives the verdict.
module keycode_to_keysym_mapper_tb;
    import kkm_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int PIPE_DRAIN = 4;
    localparam int RANDOM_ITEMS = 1640;
    localparam logic [1:0] KS_REPEAT = 2'd2;
    localparam logic [1:0] KS_UNUSED = 2'd3;
    localparam logic KIND_KEY = 1'b0;
    localparam logic KIND_LED_RESET = 1'b1;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_kind = 1'b0;
    logic [1:0]  s_key_state = 2'd0;
    logic [15:0] s_key_code = 16'd0;
    logic        s_led_numlock = 1'b0;
    logic        s_led_capslock = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_delivered;
    logic [6:0]  m_out_code;
    sym_t        m_keysym;
    logic [5:0]  m_modifiers;

    int fail_count;
    int pending_syms;
    int delivered_count;
    int send_idle_pct = 37;
    int recv_idle_pct = 50;
    int hold_off_cycles = 0;
    int quiet_cycles = 0;
    int requests_sent = 0;
    bit timed_out = 1'b0;

    keycode_to_keysym_mapper dut (.*);

    keycode_to_keysym_mapper_checker checker_i (.*);

    // 100 MHz clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    always @(posedge aclk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on cycles in which nothing is accepted.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) timed_out <= 1'b1;
        end
    end

    // Send one request and wait for it to be accepted; valid drops only while idling.
    task automatic send_key(input logic kind, input logic [1:0] st, input logic [15:0] code,
                            input logic num_led, input logic caps_led);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= kind;
        s_key_state <= st;
        s_key_code <= code;
        s_led_numlock <= num_led;
        s_led_capslock <= caps_led;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
    endtask

    function automatic int modifier_pick();
        case ($urandom_range(9))
            0: return 29; 1: return 97; 2: return 42; 3: return 54; 4: return 56;
            5: return 100; 6: return 58; 7: return 69; 8: return 125;
            default: return 126;
        endcase
    endfunction

    // Pick a key code, mostly inside the table, with modifier keys favored.
    function automatic logic [15:0] pick_code();
        int sel;
        sel = $urandom_range(99);
        if (sel < 12) return 16'(modifier_pick());
        if (sel < 90) return 16'($urandom_range(TABLE_SIZE - 1));
        if (sel < 95) return 16'($urandom_range(255, TABLE_SIZE));
        return 16'($urandom);
    endfunction

    task automatic random_key();
        if ($urandom_range(99) < 4)
            send_key(KIND_LED_RESET, 2'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
        else
            send_key(KIND_KEY, 2'($urandom_range(3)), pick_code(), 1'($urandom),
                     1'($urandom));
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset items, locks, held modifiers, edge codes, unused state.
        send_key(KIND_LED_RESET, KS_RELEASE, 16'hffff, 1'b1, 1'b1);
        send_key(KIND_KEY, KS_PRESS, 16'd71, 1'b0, 1'b0);
        send_key(KIND_KEY, KS_PRESS, 16'd16, 1'b0, 1'b0);
        send_key(KIND_KEY, KS_PRESS, 16'd42, 1'b0, 1'b0);
        send_key(KIND_KEY, KS_REPEAT, 16'd2, 1'b0, 1'b0);
        send_key(KIND_KEY, KS_UNUSED, 16'd30, 1'b0, 1'b0);
        send_key(KIND_KEY, KS_RELEASE, 16'd42, 1'b0, 1'b0);
        send_key(KIND_KEY, KS_PRESS, 16'd69, 1'b0, 1'b0);
        send_key(KIND_KEY, KS_PRESS, 16'd71, 1'b0, 1'b0);
        send_key(KIND_KEY, KS_PRESS, 16'd58, 1'b0, 1'b0);
        send_key(KIND_KEY, KS_REPEAT, 16'd58, 1'b0, 1'b0);
        send_key(KIND_KEY, KS_RELEASE, 16'd58, 1'b0, 1'b0);
        send_key(KIND_KEY, KS_PRESS, 16'd29, 1'b0, 1'b0);
        send_key(KIND_KEY, KS_PRESS, 16'd56, 1'b0, 1'b0);
        send_key(KIND_KEY, KS_PRESS, 16'd125, 1'b0, 1'b0);
        send_key(KIND_KEY, KS_PRESS, 16'd126, 1'b0, 1'b0);
        send_key(KIND_KEY, KS_RELEASE, 16'd30, 1'b0, 1'b0);
        send_key(KIND_KEY, KS_PRESS, 16'd0, 1'b0, 1'b0);
        send_key(KIND_KEY, KS_PRESS, 16'd84, 1'b0, 1'b0);
        send_key(KIND_KEY, KS_PRESS, 16'd127, 1'b0, 1'b0);
        send_key(KIND_KEY, KS_PRESS, 16'hffff, 1'b0, 1'b0);
        send_key(KIND_LED_RESET, KS_PRESS, 16'd0, 1'b0, 1'b0);

        // Pause until everything sent so far has come back.
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_syms != 0) @(posedge aclk);

        // Long receiver hold-off while requests keep coming, so the input backs up.
        hold_off_cycles <= 60;
        repeat (20) random_key();

        // Random traffic in three idling phases.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 3) begin
                send_idle_pct = 50;
                recv_idle_pct = 37;
            end else if (i == 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_key();
        end
        s_valid <= 1'b0;
    end

    // Verdict once all requests are in and answered, or on a timeout.
    initial begin
        wait (aresetn);
        while (!timed_out && !(requests_sent >= RANDOM_ITEMS + 42 && pending_syms == 0))
            @(posedge aclk);
        if (!timed_out) repeat (PIPE_DRAIN) @(posedge aclk);
        if (timed_out) begin
            $display("Timeout: no request or result moved for %0d cycles.", STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
        end else begin
            $display("Sent %0d requests (key events, LED resets, out-of-table codes).",
                     requests_sent);
            $display("%0d keysyms delivered, with stalls and backpressure on both sides.",
                     delivered_count);
            if (fail_count == 0 && pending_syms == 0) begin
                $display("SCOREBOARD CLEAN");
            end else begin
                $display("SCOREBOARD MISMATCH");
            end
        end
        $finish;
    end
endmodule
